@@ src/bdpk_pkg.sv @@
package bdpk_pkg;

  // Bus cycle and key event codes
  typedef enum logic [2:0] {
    KIND_MEM_RD = 3'd0,
    KIND_MEM_WR = 3'd1,
    KIND_IO_RD  = 3'd2,
    KIND_IO_WR  = 3'd3,
    KIND_KEY_DN = 3'd4,
    KIND_KEY_UP = 3'd5
  } kind_e;

  // Keyboard matrix geometry
  localparam int KEY_COLUMNS  = 12;
  localparam int HALF_COLUMNS = KEY_COLUMNS / 2;
  localparam logic [5:0] SCAN_IDLE = 6'h3F;

  // I/O port groups, compared against port bits 7:4
  localparam logic [3:0] PORT_GRP_KBD  = 4'h0;
  localparam logic [3:0] PORT_GRP_UART = 4'h2;
  localparam logic [3:0] PORT_GRP_PAGE = 4'h7;

  // Page register fields
  localparam logic [2:0] PAGE_TYPE_RAM = 3'b001;
  localparam int OFFSET_BITS = 14;
  localparam int ADDR_BITS   = 19;

  typedef logic [3:0][7:0] page_table_t;

  typedef struct packed {
    logic                 mem_select;
    logic [ADDR_BITS-1:0] mapped_address;
    logic                 select_ram;
    logic                 ram_write_enable;
    logic [7:0]           read_data;
    logic                 read_data_valid;
    logic                 uart_select;
    logic [2:0]           uart_register;
  } result_t;

endpackage

@@ src/bdpk_decode.sv @@
module bdpk_decode #(
  parameter int MATRIX_ROWS = 4
) (
  input  logic [2:0]                           kind_i,
  input  logic [15:0]                          bus_address_i,
  input  bdpk_pkg::page_table_t                page_table_i,
  input  logic                                 paging_on_i,
  input  logic [MATRIX_ROWS*bdpk_pkg::KEY_COLUMNS-1:0] pressed_keys_i,
  output bdpk_pkg::result_t                    result_o
);

  logic [7:0] page;
  logic [5:0] scan;

  // Scan the matrix: a pressed key pulls its data bit low when its row line is low
  always_comb begin
    scan = bdpk_pkg::SCAN_IDLE;
    for (int r = 0; r < MATRIX_ROWS; r++) begin
      for (int c = 0; c < bdpk_pkg::KEY_COLUMNS; c++) begin
        if (pressed_keys_i[r*bdpk_pkg::KEY_COLUMNS + c]) begin
          if (c >= bdpk_pkg::HALF_COLUMNS) begin
            if (!bus_address_i[r+12]) scan[c-bdpk_pkg::HALF_COLUMNS] = 1'b0;
          end else begin
            if (!bus_address_i[11-r]) scan[bdpk_pkg::HALF_COLUMNS-1-c] = 1'b0;
          end
        end
      end
    end
  end

  assign page = page_table_i[bus_address_i[15:14]];

  // Decode one bus cycle into its result word
  always_comb begin
    result_o = '0;
    case (bdpk_pkg::kind_e'(kind_i))
      bdpk_pkg::KIND_MEM_RD, bdpk_pkg::KIND_MEM_WR: begin
        result_o.mem_select = 1'b1;
        result_o.mapped_address = {5'b0, bus_address_i[bdpk_pkg::OFFSET_BITS-1:0]};
        if (paging_on_i) begin
          result_o.select_ram = (page[7:5] == bdpk_pkg::PAGE_TYPE_RAM);
          result_o.mapped_address = {page[4:0], bus_address_i[bdpk_pkg::OFFSET_BITS-1:0]};
        end
        result_o.ram_write_enable =
          (bdpk_pkg::kind_e'(kind_i) == bdpk_pkg::KIND_MEM_WR) && result_o.select_ram;
      end
      bdpk_pkg::KIND_IO_RD: begin
        if (bus_address_i[7:4] == bdpk_pkg::PORT_GRP_KBD) begin
          result_o.read_data = {2'b00, scan};
          result_o.read_data_valid = 1'b1;
        end else if (bus_address_i[7:4] == bdpk_pkg::PORT_GRP_UART) begin
          result_o.uart_select = 1'b1;
          result_o.uart_register = bus_address_i[2:0];
        end
      end
      bdpk_pkg::KIND_IO_WR: begin
        if (bus_address_i[7:4] == bdpk_pkg::PORT_GRP_UART) begin
          result_o.uart_select = 1'b1;
          result_o.uart_register = bus_address_i[2:0];
        end
      end
      default: result_o = '0;
    endcase
  end

endmodule

@@ src/bus_decoder_paging_keyboard_top.sv @@
// Bus decoder with memory paging and keyboard matrix scan.
// Input channel (in_valid_i / in_stall_o): one word per CPU bus cycle or key
// event: kind, bus address, write data, key row and column.
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word, in order: memory select, 19-bit mapped address, RAM select,
// RAM write enable, keyboard scan data, UART select and register.
// An accepted word goes straight to the output register when that is free or
// being taken. Throughput is one word per cycle while the skid is empty;
// decode is a single pass of shallow logic ahead of the output register.
// Page registers, paging enable and the pressed-key map update at the edge
// that accepts the word; each result sees the state left by earlier words.
// When the receiver stalls, a second word is caught in a skid register;
// in_stall_o rises only while that skid register is full.
// Reset clears the page registers, disables paging, releases all keys and
// empties both output registers.
module bus_decoder_paging_keyboard_top #(
  parameter int MATRIX_ROWS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [1:0]  key_row_i,
  input  logic [3:0]  key_column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        mem_select_o,
  output logic [18:0] mapped_address_o,
  output logic        select_ram_o,
  output logic        ram_write_enable_o,
  output logic [7:0]  read_data_o,
  output logic        read_data_valid_o,
  output logic        uart_select_o,
  output logic [2:0]  uart_register_o
);

  localparam int KeyBits = MATRIX_ROWS * bdpk_pkg::KEY_COLUMNS;

  bdpk_pkg::page_table_t page_q;
  logic                  paging_on_q;
  logic [KeyBits-1:0]    keys_q, keys_d;

  bdpk_pkg::result_t res;
  bdpk_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              accept, take;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign take       = out_valid_q && !out_stall_i;

  bdpk_decode #(
    .MATRIX_ROWS(MATRIX_ROWS)
  ) u_decode (
    .kind_i        (kind_i),
    .bus_address_i (bus_address_i),
    .page_table_i  (page_q),
    .paging_on_i   (paging_on_q),
    .pressed_keys_i(keys_q),
    .result_o      (res)
  );

  // Set or clear the addressed key; keys outside the matrix match no bit
  always_comb begin
    keys_d = keys_q;
    for (int r = 0; r < MATRIX_ROWS; r++) begin
      for (int c = 0; c < bdpk_pkg::KEY_COLUMNS; c++) begin
        if (key_row_i == 2'(r) && key_column_i == 4'(c)) begin
          if (bdpk_pkg::kind_e'(kind_i) == bdpk_pkg::KIND_KEY_DN) begin
            keys_d[r*bdpk_pkg::KEY_COLUMNS + c] = 1'b1;
          end else if (bdpk_pkg::kind_e'(kind_i) == bdpk_pkg::KIND_KEY_UP) begin
            keys_d[r*bdpk_pkg::KEY_COLUMNS + c] = 1'b0;
          end
        end
      end
    end
  end

  // Update paging and key state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q      <= '0;
      paging_on_q <= 1'b0;
      keys_q      <= '0;
    end else if (accept) begin
      keys_q <= keys_d;
      if (bdpk_pkg::kind_e'(kind_i) == bdpk_pkg::KIND_IO_WR &&
          bus_address_i[7:4] == bdpk_pkg::PORT_GRP_PAGE) begin
        if (!bus_address_i[2]) begin
          page_q[bus_address_i[1:0]] <= write_data_i;
        end else begin
          paging_on_q <= write_data_i[0];
        end
      end
    end
  end

  // Track output and skid occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (out_valid_q && out_stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result words; drain the skid into the output when it moves
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_q <= skid_q;
    end else if (accept) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mem_select_o       = out_q.mem_select;
  assign mapped_address_o   = out_q.mapped_address;
  assign select_ram_o       = out_q.select_ram;
  assign ram_write_enable_o = out_q.ram_write_enable;
  assign read_data_o        = out_q.read_data;
  assign read_data_valid_o  = out_q.read_data_valid;
  assign uart_select_o      = out_q.uart_select;
  assign uart_register_o    = out_q.uart_register;

endmodule

@@ src/bdpk_checker.sv @@
module bdpk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        mem_select_o,
  input logic [18:0] mapped_address_o,
  input logic        select_ram_o,
  input logic        ram_write_enable_o,
  input logic [7:0]  read_data_o,
  input logic        read_data_valid_o,
  input logic        uart_select_o
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mapped_address_o)
      && $stable(read_data_o))
    else $error("stalled result word changed");

  // Input stalls only while a result is waiting in front of the skid word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // After a word is accepted the output holds a valid word next cycle
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word lost");

  // Memory results never drive I/O fields
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_select_o |-> !read_data_valid_o && !uart_select_o)
    else $error("memory result drives I/O fields");

  // RAM writes only go to RAM on a memory cycle
  a_ram_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ram_write_enable_o |-> mem_select_o && select_ram_o)
    else $error("RAM write enable without RAM select");

endmodule

bind bus_decoder_paging_keyboard_top bdpk_checker u_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int MATRIX_ROWS_TB = 4;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  // Kind codes the block must treat as no-ops
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // I/O ports used by the directed cases
  localparam logic [15:0] PORT_KBD       = 16'h0000;
  localparam logic [15:0] PORT_UART_BASE = 16'h0020;
  localparam logic [15:0] PORT_PAGE_BASE = 16'h0070;
  localparam logic [15:0] PORT_PAGING_EN = 16'h0074;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  kind = '0;
  logic [15:0] bus_address = '0;
  logic [7:0]  write_data = '0;
  logic [1:0]  key_row = '0;
  logic [3:0]  key_column = '0;
  logic        out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        mem_select_o;
  logic [18:0] mapped_address_o;
  logic        select_ram_o;
  logic        ram_write_enable_o;
  logic [7:0]  read_data_o;
  logic        read_data_valid_o;
  logic        uart_select_o;
  logic [2:0]  uart_register_o;

  // Shadow copy of the decoder state
  logic [7:0]  page_regs [4];
  logic        paging_enabled;
  logic [47:0] key_map;

  bdpk_pkg::result_t expected_results [$];
  int          errors = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  bus_decoder_paging_keyboard_top #(
    .MATRIX_ROWS(MATRIX_ROWS_TB)
  ) i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind),
    .bus_address_i      (bus_address),
    .write_data_i       (write_data),
    .key_row_i          (key_row),
    .key_column_i       (key_column),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .mem_select_o       (mem_select_o),
    .mapped_address_o   (mapped_address_o),
    .select_ram_o       (select_ram_o),
    .ram_write_enable_o (ram_write_enable_o),
    .read_data_o        (read_data_o),
    .read_data_valid_o  (read_data_valid_o),
    .uart_select_o      (uart_select_o),
    .uart_register_o    (uart_register_o)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Decode one bus word against the shadow state, then apply its side effects
  task automatic decode_bus_word(input logic [2:0] k, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [1:0] row,
                                 input logic [3:0] col, output bdpk_pkg::result_t res);
    logic [7:0] page;
    logic [5:0] scan;
    int         idx;
    res = '0;
    case (k)
      bdpk_pkg::KIND_MEM_RD, bdpk_pkg::KIND_MEM_WR: begin
        res.mem_select = 1'b1;
        res.mapped_address = {5'b0, addr[13:0]};
        if (paging_enabled) begin
          page = page_regs[addr[15:14]];
          res.select_ram = (page[7:5] == bdpk_pkg::PAGE_TYPE_RAM);
          res.mapped_address = {page[4:0], addr[13:0]};
        end
        res.ram_write_enable = (k == bdpk_pkg::KIND_MEM_WR) && res.select_ram;
      end
      bdpk_pkg::KIND_IO_RD: begin
        if (addr[7:4] == bdpk_pkg::PORT_GRP_KBD) begin
          // Scan: a pressed key pulls its bit low when its row line is low
          scan = bdpk_pkg::SCAN_IDLE;
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < bdpk_pkg::KEY_COLUMNS; c++) begin
              if (r < MATRIX_ROWS_TB && key_map[r * bdpk_pkg::KEY_COLUMNS + c]) begin
                if (c >= bdpk_pkg::HALF_COLUMNS) begin
                  if (!addr[r + 12]) scan[c - bdpk_pkg::HALF_COLUMNS] = 1'b0;
                end else if (!addr[11 - r]) begin
                  scan[bdpk_pkg::HALF_COLUMNS - 1 - c] = 1'b0;
                end
              end
            end
          end
          res.read_data = {2'b00, scan};
          res.read_data_valid = 1'b1;
        end else if (addr[7:4] == bdpk_pkg::PORT_GRP_UART) begin
          res.uart_select = 1'b1;
          res.uart_register = addr[2:0];
        end
      end
      bdpk_pkg::KIND_IO_WR: begin
        if (addr[7:4] == bdpk_pkg::PORT_GRP_PAGE) begin
          if (!addr[2]) page_regs[addr[1:0]] = data;
          else paging_enabled = data[0];
        end else if (addr[7:4] == bdpk_pkg::PORT_GRP_UART) begin
          res.uart_select = 1'b1;
          res.uart_register = addr[2:0];
        end
      end
      bdpk_pkg::KIND_KEY_DN, bdpk_pkg::KIND_KEY_UP: begin
        if (col < bdpk_pkg::KEY_COLUMNS && row < MATRIX_ROWS_TB) begin
          idx = row * bdpk_pkg::KEY_COLUMNS + col;
          key_map[idx] = (k == bdpk_pkg::KIND_KEY_DN);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word, hold it until accepted, then queue its decode
  task automatic send_word(input logic [2:0] k, input logic [15:0] addr,
                           input logic [7:0] data, input logic [1:0] row,
                           input logic [3:0] col);
    bdpk_pkg::result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    bus_address <= addr;
    write_data  <= data;
    key_row     <= row;
    key_column  <= col;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    decode_bus_word(k, addr, data, row, col, res);
    expected_results = {expected_results, res};
    words_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Receive side: check accepted words
  always @(posedge clk) begin : result_checker
    bdpk_pkg::result_t want;
    if (out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word with no pending decode, mapped_address 0x%0h",
                 $time, mapped_address_o);
      end else begin
        want = expected_results.pop_front();
        check_field("mem_select", 32'(want.mem_select), 32'(mem_select_o));
        check_field("mapped_address", 32'(want.mapped_address), 32'(mapped_address_o));
        check_field("select_ram", 32'(want.select_ram), 32'(select_ram_o));
        check_field("ram_write_enable", 32'(want.ram_write_enable),
                    32'(ram_write_enable_o));
        check_field("read_data", 32'(want.read_data), 32'(read_data_o));
        check_field("read_data_valid", 32'(want.read_data_valid), 32'(read_data_valid_o));
        check_field("uart_select", 32'(want.uart_select), 32'(uart_select_o));
        check_field("uart_register", 32'(want.uart_register), 32'(uart_register_o));
        results_checked++;
      end
    end
  end

  // Receive side: count out a long hold when asked, else stall at random
  always @(posedge clk) begin : receiver_pacing
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Field extremes, every kind, paging, UART, ignored keys and spare kinds
  task automatic run_directed_cases();
    send_word(bdpk_pkg::KIND_MEM_RD, 16'h0000, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_WR, 16'hFFFF, 8'hFF, 2'd3, 4'd15);
    send_word(bdpk_pkg::KIND_IO_RD, PORT_KBD, 8'h00, 2'd0, 4'd0);
    // Load pages: RAM, RAM with all low bits, ROM all ones, ROM top page
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGE_BASE + 16'd0, 8'h20, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGE_BASE + 16'd1, 8'h3F, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGE_BASE + 16'd2, 8'hFF, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGE_BASE + 16'd3, 8'h1F, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGING_EN, 8'h01, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_WR, 16'h0000, 8'hA5, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_WR, 16'h7FFF, 8'h5A, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_RD, 16'hBFFF, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_WR, 16'hC000, 8'h00, 2'd0, 4'd0);
    // Read of a page port changes nothing
    send_word(bdpk_pkg::KIND_IO_RD, PORT_PAGE_BASE, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_RD, PORT_UART_BASE + 16'h000F, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, PORT_UART_BASE, 8'hFF, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_WR, 16'h0055, 8'hFF, 2'd0, 4'd0);
    // Keys: two corners, two outside the matrix
    send_word(bdpk_pkg::KIND_KEY_DN, 16'h0000, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_KEY_DN, 16'h0000, 8'h00, 2'd3, 4'd11);
    send_word(bdpk_pkg::KIND_KEY_DN, 16'h0000, 8'h00, 2'd1, 4'd12);
    send_word(bdpk_pkg::KIND_KEY_DN, 16'h0000, 8'h00, 2'd2, 4'd15);
    send_word(bdpk_pkg::KIND_IO_RD, PORT_KBD, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_IO_RD, 16'hFF0F, 8'h00, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_KEY_UP, 16'h0000, 8'h00, 2'd3, 4'd11);
    send_word(KIND_SPARE_6, 16'hFFFF, 8'hFF, 2'd3, 4'd15);
    send_word(KIND_SPARE_7, 16'h0077, 8'h01, 2'd0, 4'd0);
    // Paging off via an odd enable port with bit 0 clear
    send_word(bdpk_pkg::KIND_IO_WR, PORT_PAGING_EN + 16'd3, 8'hFE, 2'd0, 4'd0);
    send_word(bdpk_pkg::KIND_MEM_RD, 16'h4000, 8'h00, 2'd0, 4'd0);
  endtask

  // Random mix biased toward the keyboard, UART and page port groups
  task automatic send_random_word();
    int          pick;
    logic [2:0]  k;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  col;
    pick = $urandom_range(99);
    addr = 16'($urandom);
    data = 8'($urandom);
    col  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
    if (pick < 35) begin
      k = (pick < 18) ? bdpk_pkg::KIND_MEM_RD : bdpk_pkg::KIND_MEM_WR;
    end else if (pick < 80) begin
      k = (pick < 60) ? bdpk_pkg::KIND_IO_RD : bdpk_pkg::KIND_IO_WR;
      case ($urandom_range(3))
        0:       addr[7:4] = bdpk_pkg::PORT_GRP_KBD;
        1:       addr[7:4] = bdpk_pkg::PORT_GRP_UART;
        2:       addr[7:4] = bdpk_pkg::PORT_GRP_PAGE;
        default: ;
      endcase
      // Favor RAM-type pages so paged writes land in RAM often
      if (addr[7:4] == bdpk_pkg::PORT_GRP_PAGE && $urandom_range(1)) begin
        data[7:5] = bdpk_pkg::PAGE_TYPE_RAM;
      end
    end else if (pick < 98) begin
      k = (pick < 89) ? bdpk_pkg::KIND_KEY_DN : bdpk_pkg::KIND_KEY_UP;
    end else begin
      k = pick[0] ? KIND_SPARE_7 : KIND_SPARE_6;
    end
    send_word(k, addr, data, 2'($urandom), col);
  endtask

  task automatic run_random_traffic(input int count, input int send_pct, input int rcv_pct);
    sender_idle_pct = send_pct;
    receiver_idle_pct <= rcv_pct;
    repeat (count) send_random_word();
  endtask

  // Hold off the receiver long enough to fill the output and skid registers
  task automatic run_stall_fill();
    sender_idle_pct = 0;
    receiver_idle_pct <= 0;
    hold_token <= hold_token + 1;
    repeat (40) send_random_word();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) page_regs[i] = '0;
    paging_enabled = 1'b0;
    key_map = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_cases();
    run_random_traffic(220, 13, 81);
    run_random_traffic(220, 81, 13);
    run_stall_fill();
    run_random_traffic(190, 0, 0);

    // Drop valid and drain
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d words sent, %0d results checked, %0d errors", words_sent,
             results_checked, errors);
    $display("tb: covered paging on and off, RAM and ROM pages, keyboard scans, UART ports");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/bdpk_pkg.sv
src/bdpk_decode.sv
src/bus_decoder_paging_keyboard_top.sv
src/bdpk_checker.sv
dv/tb_top.sv
